// ----- hw/rtl/cpd_pkg.sv -----
// cpd_pkg: types, codes and crc helpers shared by the packet deframer modules
// no dependencies
`default_nettype none

package cpd_pkg;

	// input command codes
	localparam logic [1:0] OP_BYTE     = 2'd0;
	localparam logic [1:0] OP_CANCEL   = 2'd1;
	localparam logic [1:0] OP_LINK_ERR = 2'd2;
	// op value with no meaning, dropped by the front
	localparam logic [1:0] OP_UNUSED   = 2'd3;

	// end status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CRC_BAD  = 2'd1;
	localparam logic [1:0] ST_CANCELED = 2'd2;
	localparam logic [1:0] ST_LINK_ERR = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC8_POLY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CRC8_SEED   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRC16_POLY  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CRC16_SEED  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd5;

	// register reset values
	localparam logic [7:0]  SYNC_BYTE_RST   = 8'hAA;
	localparam logic [7:0]  CRC8_POLY_RST   = 8'h37;
	localparam logic [7:0]  CRC8_SEED_RST   = 8'h42;
	localparam logic [15:0] CRC16_POLY_RST  = 16'h3D65;
	localparam logic [15:0] CRC16_SEED_RST  = 16'h1337;
	localparam logic [6:0]  MAX_PAYLOAD_RST = 7'd127;

	// default queue depths
	localparam int IQ_DEPTH_DEF = 2;
	localparam int OQ_DEPTH_DEF = 2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_end;
		logic [1:0] status;
		logic [6:0] pkt_length;
	} out_item_t;

	typedef enum logic [1:0] {
		K_BYTE,
		K_CANCEL,
		K_LINK_ERR
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  sync_byte;
		logic [7:0]  crc8_poly;
		logic [7:0]  crc8_seed;
		logic [15:0] crc16_poly;
		logic [15:0] crc16_seed;
		logic [6:0]  max_payload;
	} cfg_t;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_PAYLOAD,
		PH_TRAILER
	} phase_t;

	typedef enum logic [1:0] {
		RB_IDLE,
		RB_STEP1,
		RB_STEP2
	} rebuild_t;

	// one byte through an msb-first crc8
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// one byte through an msb-first crc16
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b,
		input logic [15:0] poly);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cpd_front.sv -----
// cpd_front: accepts input beats, classifies them and queues commands for the engine
// depends on cpd_pkg
`default_nettype none

module cpd_front #(
	parameter int IQ_DEPTH = cpd_pkg::IQ_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire cpd_pkg::in_item_t rx_item,
	output logic                  cmd_valid,
	output cpd_pkg::cmd_t         cmd,
	input  wire logic             cmd_take
);
	import cpd_pkg::*;

	localparam int PW = (IQ_DEPTH > 1) ? $clog2(IQ_DEPTH) : 1;
	localparam int CW = $clog2(IQ_DEPTH + 1);

	cmd_t            mem_q [IQ_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	cmd_t            cls;
	logic            keep;
	logic            enq;
	logic            deq;

	// sort the op code; the unused code is dropped here
	always_comb begin
		cls.data = rx_item.rx_byte;
		cls.kind = K_BYTE;
		keep = 1'b1;
		case (rx_item.op)
			OP_BYTE:     cls.kind = K_BYTE;
			OP_CANCEL:   cls.kind = K_CANCEL;
			OP_LINK_ERR: cls.kind = K_LINK_ERR;
			default:     keep = 1'b0;
		endcase
	end

	assign full      = (cnt_q == CW'(IQ_DEPTH));
	assign enq       = push && !full && keep;
	assign cmd_valid = (cnt_q != '0);
	assign deq       = cmd_take && cmd_valid;
	assign cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == PW'(IQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PW'(IQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(IQ_DEPTH))
		else $error("command queue over depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && rx_item.op == OP_UNUSED) |=> $stable(cnt_q) || $past(deq))
		else $error("unused op code was queued");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty command queue with split pointers");

endmodule

`default_nettype wire

// ----- hw/rtl/cpd_engine.sv -----
// cpd_engine: header hunt, payload pass-through and trailer check, one command a cycle
// unless stalled by a full result queue or a window refresh; depends on cpd_pkg
`default_nettype none

module cpd_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cpd_pkg::cfg_t   cfg,
	input  wire logic            crc8_cfg_wr,
	input  wire logic            cmd_valid,
	input  wire cpd_pkg::cmd_t   cmd,
	output logic                 cmd_take,
	input  wire logic            res_ready,
	output logic                 res_valid,
	output cpd_pkg::out_item_t   res
);
	import cpd_pkg::*;

	phase_t      phase_q, phase_d;
	rebuild_t    rb_q;
	logic [1:0]  fill_q;
	logic [7:0]  w0_q, w1_q;
	logic [7:0]  c0_q, c1_q;     // crc8 from seed over window bytes starting at 0 and at 1
	logic [6:0]  acc_len_q;
	logic [6:0]  seen_q;
	logic [15:0] crc_q;
	logic        tr_seen_q;

	logic [7:0]  a0, x0, a1, x1;
	logic [7:0]  u0, u1, u2;
	logic [15:0] u16;
	logic [6:0]  seen_next;
	logic [6:0]  cap_len;
	logic        is_byte;
	logic        bad_sync, bad_len, bad_crc, hdr_ok;

	assign cmd_take = cmd_valid && res_ready && (rb_q == RB_IDLE);
	assign is_byte  = (cmd.kind == K_BYTE);

	// three crc8 units: two extend the running window chains, one starts a new chain
	always_comb begin
		a0 = c0_q;
		x0 = cmd.data;
		a1 = c1_q;
		x1 = cmd.data;
		case (rb_q)
			RB_STEP1: begin
				a0 = cfg.crc8_seed;
				x0 = w0_q;
				a1 = cfg.crc8_seed;
				x1 = w1_q;
			end
			RB_STEP2: begin
				a0 = c0_q;
				x0 = w1_q;
			end
			default: ;
		endcase
	end

	assign u0  = crc8_byte(a0, x0, cfg.crc8_poly);
	assign u1  = crc8_byte(a1, x1, cfg.crc8_poly);
	assign u2  = crc8_byte(cfg.crc8_seed, cmd.data, cfg.crc8_poly);
	assign u16 = crc16_byte(crc_q, cmd.data, cfg.crc16_poly);

	assign seen_next = seen_q + 1'b1;
	assign cap_len   = (w1_q[6:0] < cfg.max_payload) ? w1_q[6:0] : cfg.max_payload;
	assign bad_sync  = (w0_q != cfg.sync_byte);
	assign bad_len   = w1_q[7];
	assign bad_crc   = (u0 != 8'h00);
	assign hdr_ok    = (fill_q == 2'd2) && !bad_sync && !bad_len && !bad_crc;

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (cmd_take) begin
			if (!is_byte) begin
				phase_d = PH_HUNT;
			end else begin
				case (phase_q)
					PH_HUNT: begin
						if (hdr_ok) begin
							phase_d = (cap_len == 7'd0) ? PH_TRAILER : PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						if (seen_next >= acc_len_q) begin
							phase_d = PH_TRAILER;
						end
					end
					PH_TRAILER: begin
						if (tr_seen_q) begin
							phase_d = PH_HUNT;
						end
					end
					default: phase_d = PH_HUNT;
				endcase
			end
		end
	end

	// result beat
	always_comb begin
		res_valid      = 1'b0;
		res.out_byte   = 8'h00;
		res.is_end     = 1'b0;
		res.status     = ST_OK;
		res.pkt_length = 7'd0;
		if (cmd_take) begin
			case (cmd.kind)
				K_CANCEL: begin
					res_valid  = 1'b1;
					res.is_end = 1'b1;
					res.status = ST_CANCELED;
				end
				K_LINK_ERR: begin
					res_valid  = 1'b1;
					res.is_end = 1'b1;
					res.status = ST_LINK_ERR;
				end
				K_BYTE: begin
					if (phase_q == PH_PAYLOAD) begin
						res_valid    = 1'b1;
						res.out_byte = cmd.data;
					end else if (phase_q == PH_TRAILER && tr_seen_q) begin
						res_valid      = 1'b1;
						res.is_end     = 1'b1;
						res.status     = (u16 != 16'h0000) ? ST_CRC_BAD : ST_OK;
						res.pkt_length = acc_len_q;
					end
				end
				default: ;
			endcase
		end
	end

	// window and chain payload
	always_ff @(posedge clk) begin
		if (rb_q == RB_STEP1) begin
			c0_q <= u0;
			c1_q <= u1;
		end else if (rb_q == RB_STEP2) begin
			c0_q <= u0;
		end else if (cmd_take && is_byte && phase_q == PH_HUNT) begin
			case (fill_q)
				2'd0: begin
					w0_q <= cmd.data;
					c0_q <= u2;
				end
				2'd1: begin
					w1_q <= cmd.data;
					c0_q <= u0;
					c1_q <= u2;
				end
				2'd2: begin
					if (bad_sync) begin
						w0_q <= w1_q;
						w1_q <= cmd.data;
						c0_q <= u1;
						c1_q <= u2;
					end else if (bad_len) begin
						w0_q <= cmd.data;
						c0_q <= u2;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			rb_q      <= RB_IDLE;
			fill_q    <= 2'd0;
			acc_len_q <= 7'd0;
			seen_q    <= 7'd0;
			crc_q     <= CRC16_SEED_RST;
			tr_seen_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			// refresh the window chains after a crc8 register write
			if (crc8_cfg_wr) begin
				rb_q <= RB_STEP1;
			end else if (rb_q == RB_STEP1) begin
				rb_q <= (fill_q == 2'd2) ? RB_STEP2 : RB_IDLE;
			end else begin
				rb_q <= RB_IDLE;
			end
			if (cmd_take) begin
				if (!is_byte) begin
					fill_q    <= 2'd0;
					seen_q    <= 7'd0;
					tr_seen_q <= 1'b0;
				end else begin
					case (phase_q)
						PH_HUNT: begin
							case (fill_q)
								2'd0: fill_q <= 2'd1;
								2'd1: fill_q <= 2'd2;
								2'd2: begin
									if (bad_sync) begin
										fill_q <= 2'd2;
									end else if (bad_len) begin
										fill_q <= 2'd1;
									end else begin
										fill_q <= 2'd0;
										if (!bad_crc) begin
											acc_len_q <= cap_len;
											crc_q     <= cfg.crc16_seed;
											seen_q    <= 7'd0;
											tr_seen_q <= 1'b0;
										end
									end
								end
								default: fill_q <= 2'd0;
							endcase
						end
						PH_PAYLOAD: begin
							crc_q  <= u16;
							seen_q <= seen_next;
						end
						PH_TRAILER: begin
							crc_q <= u16;
							if (!tr_seen_q) begin
								tr_seen_q <= 1'b1;
							end else begin
								fill_q    <= 2'd0;
								seen_q    <= 7'd0;
								tr_seen_q <= 1'b0;
							end
						end
						default: fill_q <= 2'd0;
					endcase
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HUNT) |-> (fill_q == 2'd0))
		else $error("header window not empty outside hunting");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (seen_q < acc_len_q))
		else $error("payload count ran past accepted length");
	assert property (@(posedge clk) disable iff (!arst_n)
		tr_seen_q |-> (phase_q == PH_TRAILER))
		else $error("trailer flag set outside trailer");
	assert property (@(posedge clk) disable iff (!arst_n) fill_q != 2'd3)
		else $error("header window overfilled");

endmodule

`default_nettype wire

// ----- hw/rtl/cpd_outq.sv -----
// cpd_outq: result queue between the engine and the consumer
// depends on cpd_pkg
`default_nettype none

module cpd_outq #(
	parameter int OQ_DEPTH = cpd_pkg::OQ_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               res_valid,
	input  wire cpd_pkg::out_item_t res,
	output logic                    res_ready,
	output logic                    empty,
	input  wire logic               pop,
	output cpd_pkg::out_item_t      result
);
	import cpd_pkg::*;

	localparam int PW = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
	localparam int CW = $clog2(OQ_DEPTH + 1);

	out_item_t       mem_q [OQ_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            enq, deq;

	assign res_ready = (cnt_q != CW'(OQ_DEPTH));
	assign empty     = (cnt_q == '0);
	assign enq       = res_valid && res_ready;
	assign deq       = pop && !empty;
	assign result    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == PW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) res_valid |-> res_ready)
		else $error("engine produced a result with no room");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(OQ_DEPTH))
		else $error("result queue over depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !res_valid) |=> empty)
		else $error("result appeared with nothing written");

endmodule

`default_nettype wire

// ----- hw/rtl/crc_packet_deframer.sv -----
// Receive deframer for sync / length / crc8 headers with a big-endian crc16 trailer. Input
// beats (a received byte, a cancel or a link error) go in through a queue-style push/full
// port; results come out through an empty/pop port, oldest first. While hunting, the block
// slides a three-byte window over the byte stream looking for a valid header; nothing is
// reported for header bytes. Each payload byte is passed out as soon as it arrives, and an
// end beat follows the two trailer bytes with status ok or crc_bad and the accepted length.
// Cancel and link error give an end beat at once and restart the hunt. The block takes one
// input beat every clock while neither queue is full and no window refresh runs, and gives
// at most one result beat every clock; a beat waits in the command queue and its result in
// the result queue. That pace is set by one pass a cycle through three 8-bit crc units (the
// window chains) and one 16-bit crc unit in the engine. After a write to the crc8 polynomial
// or seed register the engine refreshes the partial header crcs of the window; input beats
// queue up meanwhile. This file holds the top level and the configuration registers; it
// depends on cpd_pkg, cpd_front, cpd_engine and cpd_outq.
`default_nettype none

module crc_packet_deframer #(
	parameter int IQ_DEPTH = cpd_pkg::IQ_DEPTH_DEF,
	parameter int OQ_DEPTH = cpd_pkg::OQ_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input beats
	input  wire logic                            push,
	output logic                                 full,
	input  wire cpd_pkg::in_item_t               rx_item,
	// result beats
	output logic                                 empty,
	input  wire logic                            pop,
	output cpd_pkg::out_item_t                   result,
	// register writes
	input  wire logic                            cfg_we,
	input  wire logic [cpd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [cpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cpd_pkg::*;

	cfg_t      cfg_q;
	logic      crc8_cfg_wr;
	logic      cmd_valid;
	cmd_t      cmd;
	logic      cmd_take;
	logic      res_ready;
	logic      res_valid;
	out_item_t res;

	// configuration registers, to be written by the user only while the block is idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte   <= SYNC_BYTE_RST;
			cfg_q.crc8_poly   <= CRC8_POLY_RST;
			cfg_q.crc8_seed   <= CRC8_SEED_RST;
			cfg_q.crc16_poly  <= CRC16_POLY_RST;
			cfg_q.crc16_seed  <= CRC16_SEED_RST;
			cfg_q.max_payload <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SYNC_BYTE:   cfg_q.sync_byte   <= cfg_data[7:0];
				REG_CRC8_POLY:   cfg_q.crc8_poly   <= cfg_data[7:0];
				REG_CRC8_SEED:   cfg_q.crc8_seed   <= cfg_data[7:0];
				REG_CRC16_POLY:  cfg_q.crc16_poly  <= cfg_data;
				REG_CRC16_SEED:  cfg_q.crc16_seed  <= cfg_data;
				REG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data[6:0];
				default: ;   // unused index, ignored
			endcase
		end
	end

	// a new crc8 polynomial or seed invalidates the partial window crcs
	assign crc8_cfg_wr = cfg_we && (cfg_idx == REG_CRC8_POLY || cfg_idx == REG_CRC8_SEED);

	// front: accept and classify input beats
	cpd_front #(
		.IQ_DEPTH (IQ_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_item   (rx_item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// back: header hunt, payload and trailer
	cpd_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.crc8_cfg_wr (crc8_cfg_wr),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_take    (cmd_take),
		.res_ready   (res_ready),
		.res_valid   (res_valid),
		.res         (res)
	);

	// result beats wait here until popped
	cpd_outq #(
		.OQ_DEPTH (OQ_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// an end beat never carries a payload byte; only packet ends carry a length
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.is_end) |-> (result.out_byte == 8'h00))
		else $error("end beat with nonzero byte");
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (!result.is_end || result.status == ST_CANCELED
		|| result.status == ST_LINK_ERR)) |-> (result.pkt_length == 7'd0))
		else $error("length on a beat that must not carry one");
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.is_end) |-> (result.status == ST_OK))
		else $error("payload beat with nonzero status");

endmodule

`default_nettype wire
